// ===== rtl/acomb_pkg.sv =====
`timescale 1ns / 1ps
package acomb_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 32;
  localparam int SUM_W      = 34;
  localparam int ACC_W      = 35;
  localparam int OUT_W      = 20;
  localparam int CFG_W      = 12;
  localparam int FRAC_SHIFT = 15;
  localparam int NUM_PROD   = 8;

  localparam int DEF_MAX_VECTOR_LENGTH = 2048;
  localparam int LEN_RESET             = 64;
  localparam int LEN_MIN               = 2;

  // half an output lsb, folded into the stored partial sums
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_SHIFT - 1));

  typedef struct packed {
    logic [SAMPLE_W-1:0] rx0_re;
    logic [SAMPLE_W-1:0] rx0_im;
    logic [SAMPLE_W-1:0] rx1_re;
    logic [SAMPLE_W-1:0] rx1_im;
    logic [SAMPLE_W-1:0] chan0_re;
    logic [SAMPLE_W-1:0] chan0_im;
    logic [SAMPLE_W-1:0] chan1_re;
    logic [SAMPLE_W-1:0] chan1_im;
    logic [SAMPLE_W-1:0] chan2_re;
    logic [SAMPLE_W-1:0] chan2_im;
    logic [SAMPLE_W-1:0] chan3_re;
    logic [SAMPLE_W-1:0] chan3_im;
  } sample_t;

  typedef struct packed {
    sample_t d;
    logic    odd;
    logic    last;
  } stage0_t;

  typedef struct packed {
    logic [NUM_PROD-1:0][PROD_W-1:0] prod;
    logic                            odd;
    logic                            last;
  } stage1_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_re;
    logic [SUM_W-1:0] sum_im;
    logic             odd;
    logic             last;
  } stage2_t;

endpackage

// ===== rtl/acomb_if.sv =====
`timescale 1ns / 1ps
interface acomb_in_if;
  import acomb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] rx0_re;
  logic signed [SAMPLE_W-1:0] rx0_im;
  logic signed [SAMPLE_W-1:0] rx1_re;
  logic signed [SAMPLE_W-1:0] rx1_im;
  logic signed [SAMPLE_W-1:0] chan0_re;
  logic signed [SAMPLE_W-1:0] chan0_im;
  logic signed [SAMPLE_W-1:0] chan1_re;
  logic signed [SAMPLE_W-1:0] chan1_im;
  logic signed [SAMPLE_W-1:0] chan2_re;
  logic signed [SAMPLE_W-1:0] chan2_im;
  logic signed [SAMPLE_W-1:0] chan3_re;
  logic signed [SAMPLE_W-1:0] chan3_im;
  modport source (
    output valid, rx0_re, rx0_im, rx1_re, rx1_im, chan0_re, chan0_im, chan1_re, chan1_im,
           chan2_re, chan2_im, chan3_re, chan3_im,
    input  ready
  );
  modport sink (
    input  valid, rx0_re, rx0_im, rx1_re, rx1_im, chan0_re, chan0_im, chan1_re, chan1_im,
           chan2_re, chan2_im, chan3_re, chan3_im,
    output ready
  );
endinterface

interface acomb_out_if;
  import acomb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_re;
  logic signed [OUT_W-1:0] out_im;
  logic                    run_last;
  logic                    vector_end;
  modport source (output valid, out_re, out_im, run_last, vector_end, input ready);
  modport sink (input valid, out_re, out_im, run_last, vector_end, output ready);
endinterface

interface acomb_cfg_if;
  import acomb_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] vector_length;
  modport source (output valid, vector_length, input ready);
  modport sink (input valid, vector_length, output ready);
endinterface

// ===== rtl/acomb_front.sv =====
`timescale 1ns / 1ps
module acomb_front #(
  parameter int MAX_VECTOR_LENGTH = acomb_pkg::DEF_MAX_VECTOR_LENGTH
) (
  input  logic              clk,
  input  logic              rst,
  acomb_cfg_if.sink         cfg,
  acomb_in_if.sink          samples,
  output acomb_pkg::stage0_t s0,
  output logic              s0_valid,
  input  logic              s0_ready
);
  import acomb_pkg::*;

  localparam int IDX_W     = $clog2(MAX_VECTOR_LENGTH);
  localparam int LEN_W     = IDX_W + 1;
  localparam int MAX_EVEN  = MAX_VECTOR_LENGTH - (MAX_VECTOR_LENGTH % 2);
  localparam int RESET_EFF = (LEN_RESET > MAX_EVEN) ? MAX_EVEN : LEN_RESET;

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [LEN_W-1:0] idx_inc;
  logic [CFG_W-1:0] wr_even;
  logic             take;
  logic             is_odd;
  logic             is_last;

  // effective length, clamped once at write time
  assign cfg.ready = 1'b1;
  assign wr_even   = {cfg.vector_length[CFG_W-1:1], 1'b0};

  always_comb begin
    priority if (32'(wr_even) > 32'(MAX_EVEN)) begin
      len_next = LEN_W'(MAX_EVEN);
    end else if (wr_even < CFG_W'(LEN_MIN)) begin
      len_next = LEN_W'(LEN_MIN);
    end else begin
      len_next = LEN_W'(wr_even);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_W'(RESET_EFF);
    end else if (cfg.valid && cfg.ready) begin
      len <= len_next;
    end
  end

  // subcarrier position
  assign samples.ready = !s0_valid || s0_ready;
  assign take          = samples.valid && samples.ready;
  assign idx_inc       = {1'b0, idx} + LEN_W'(1);
  assign is_odd        = idx[0];
  assign is_last       = is_odd && (idx_inc >= len);
  assign idx_next      = is_last ? '0 : idx_inc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (samples.ready) begin
      s0_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s0.d.rx0_re   <= samples.rx0_re;
      s0.d.rx0_im   <= samples.rx0_im;
      s0.d.rx1_re   <= samples.rx1_re;
      s0.d.rx1_im   <= samples.rx1_im;
      s0.d.chan0_re <= samples.chan0_re;
      s0.d.chan0_im <= samples.chan0_im;
      s0.d.chan1_re <= samples.chan1_re;
      s0.d.chan1_im <= samples.chan1_im;
      s0.d.chan2_re <= samples.chan2_re;
      s0.d.chan2_im <= samples.chan2_im;
      s0.d.chan3_re <= samples.chan3_re;
      s0.d.chan3_im <= samples.chan3_im;
      s0.odd        <= is_odd;
      s0.last       <= is_last;
    end
  end

endmodule

// ===== rtl/acomb_mult.sv =====
`timescale 1ns / 1ps
module acomb_mult (
  input  logic               clk,
  input  logic               rst,
  input  acomb_pkg::stage0_t s0,
  input  logic               s0_valid,
  output logic               s0_ready,
  output acomb_pkg::stage1_t s1,
  output logic               s1_valid,
  input  logic               s1_ready
);
  import acomb_pkg::*;

  function automatic logic [PROD_W-1:0] mul(input logic signed [SAMPLE_W-1:0] a,
                                            input logic signed [SAMPLE_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    p   = PROD_W'(a) * PROD_W'(b);
    mul = p;
  endfunction

  logic signed [SAMPLE_W-1:0] ar, ai, br, bi;
  logic signed [SAMPLE_W-1:0] r0r, r0i, r1r, r1i;

  // even uses h0/h2, odd uses h1/h3
  assign ar  = $signed(s0.odd ? s0.d.chan1_re : s0.d.chan0_re);
  assign ai  = $signed(s0.odd ? s0.d.chan1_im : s0.d.chan0_im);
  assign br  = $signed(s0.odd ? s0.d.chan3_re : s0.d.chan2_re);
  assign bi  = $signed(s0.odd ? s0.d.chan3_im : s0.d.chan2_im);
  assign r0r = $signed(s0.d.rx0_re);
  assign r0i = $signed(s0.d.rx0_im);
  assign r1r = $signed(s0.d.rx1_re);
  assign r1i = $signed(s0.d.rx1_im);

  assign s0_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s0_ready) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_valid && s0_ready) begin
      s1.prod[0] <= mul(ar, r0r);
      s1.prod[1] <= mul(ai, r0i);
      s1.prod[2] <= mul(br, r1r);
      s1.prod[3] <= mul(bi, r1i);
      s1.prod[4] <= mul(ar, r0i);
      s1.prod[5] <= mul(ai, r0r);
      s1.prod[6] <= mul(br, r1i);
      s1.prod[7] <= mul(bi, r1r);
      s1.odd     <= s0.odd;
      s1.last    <= s0.last;
    end
  end

endmodule

// ===== rtl/acomb_sum.sv =====
`timescale 1ns / 1ps
module acomb_sum (
  input  logic               clk,
  input  logic               rst,
  input  acomb_pkg::stage1_t s1,
  input  logic               s1_valid,
  output logic               s1_ready,
  output acomb_pkg::stage2_t s2,
  output logic               s2_valid,
  input  logic               s2_ready
);
  import acomb_pkg::*;

  function automatic logic signed [SUM_W-1:0] sx(input logic [PROD_W-1:0] p);
    sx = SUM_W'($signed(p));
  endfunction

  logic signed [SUM_W-1:0] sum_re;
  logic signed [SUM_W-1:0] sum_im;

  // re: a.re*r0.re + a.im*r0.im + b.re*r1.re + b.im*r1.im
  // im: even form, negated later on odd words
  assign sum_re = (sx(s1.prod[0]) + sx(s1.prod[1])) + (sx(s1.prod[2]) + sx(s1.prod[3]));
  assign sum_im = (sx(s1.prod[4]) - sx(s1.prod[5])) + (sx(s1.prod[6]) - sx(s1.prod[7]));

  assign s1_ready = !s2_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      s2.sum_re <= sum_re;
      s2.sum_im <= sum_im;
      s2.odd    <= s1.odd;
      s2.last   <= s1.last;
    end
  end

endmodule

// ===== rtl/acomb_pair.sv =====
`timescale 1ns / 1ps
module acomb_pair (
  input  logic               clk,
  input  logic               rst,
  input  acomb_pkg::stage2_t s2,
  input  logic               s2_valid,
  output logic               s2_ready,
  acomb_out_if.source        symbols
);
  import acomb_pkg::*;

  logic signed [ACC_W-1:0] part_re;
  logic signed [ACC_W-1:0] part_im;
  logic signed [ACC_W-1:0] sum_re_x;
  logic signed [ACC_W-1:0] sum_im_x;
  logic signed [ACC_W-1:0] tot_re;
  logic signed [ACC_W-1:0] tot_im;
  logic [OUT_W-1:0]        sym_re;
  logic [OUT_W-1:0]        sym_im;
  logic                    first_pend;
  logic                    second_pend;
  logic                    end_flag;
  logic                    space;
  logic                    load;

  assign sum_re_x = ACC_W'($signed(s2.sum_re));
  assign sum_im_x = ACC_W'($signed(s2.sum_im));
  assign tot_re   = part_re + sum_re_x;
  assign tot_im   = part_im - sum_im_x;

  // room for a new pair when nothing is pending, or only the zero word is left and it is taken
  assign space    = !first_pend && (!second_pend || symbols.ready);
  assign s2_ready = !s2_valid || !s2.odd || space;
  assign load     = s2_valid && s2.odd && space;

  // partial sums carry the rounding offset
  always_ff @(posedge clk) begin
    if (rst) begin
      part_re <= ROUND_BIAS;
      part_im <= ROUND_BIAS;
    end else if (s2_valid && !s2.odd) begin
      part_re <= sum_re_x + ROUND_BIAS;
      part_im <= sum_im_x + ROUND_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pend  <= 1'b0;
      second_pend <= 1'b0;
    end else if (load) begin
      first_pend  <= 1'b1;
      second_pend <= 1'b1;
    end else if (symbols.valid && symbols.ready) begin
      if (first_pend) begin
        first_pend <= 1'b0;
      end else begin
        second_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sym_re   <= tot_re[FRAC_SHIFT +: OUT_W];
      sym_im   <= tot_im[FRAC_SHIFT +: OUT_W];
      end_flag <= s2.last;
    end
  end

  assign symbols.valid      = first_pend || second_pend;
  assign symbols.out_re     = $signed(first_pend ? sym_re : '0);
  assign symbols.out_im     = $signed(first_pend ? sym_im : '0);
  assign symbols.run_last   = !first_pend;
  assign symbols.vector_end = !first_pend && end_flag;

endmodule

// ===== rtl/alamouti_two_rx_combiner_core.sv =====
`timescale 1ns / 1ps
// output: after its odd subcarrier is taken, the combined word of a pair passes the input,
// product, sum and pair buffer registers; the zero word follows once that word is taken
// throughput: one subcarrier per cycle while the output is ready, through four register
// stages (input, products, sums, output pair buffer); each odd subcarrier gives two words
// reset: synchronous, clears valids, subcarrier index; partial sums to bias, length to 64
module alamouti_two_rx_combiner_core #(
  parameter int MAX_VECTOR_LENGTH = acomb_pkg::DEF_MAX_VECTOR_LENGTH
) (
  input logic          clk,
  input logic          rst,
  acomb_cfg_if.sink    cfg,
  acomb_in_if.sink     samples,
  acomb_out_if.source  symbols
);
  import acomb_pkg::*;

  stage0_t s0;
  stage1_t s1;
  stage2_t s2;
  logic    s0_valid, s0_ready;
  logic    s1_valid, s1_ready;
  logic    s2_valid, s2_ready;

  acomb_front #(
    .MAX_VECTOR_LENGTH(MAX_VECTOR_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .samples  (samples),
    .s0       (s0),
    .s0_valid (s0_valid),
    .s0_ready (s0_ready)
  );

  acomb_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .s0       (s0),
    .s0_valid (s0_valid),
    .s0_ready (s0_ready),
    .s1       (s1),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready)
  );

  acomb_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s2       (s2),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready)
  );

  acomb_pair u_pair (
    .clk      (clk),
    .rst      (rst),
    .s2       (s2),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .symbols  (symbols)
  );

`ifndef NO_ASSERTIONS
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    symbols.valid && symbols.ready && !symbols.run_last |=> symbols.valid && symbols.run_last)
    else $error("combined word not followed by its zero word");

  a_end_on_second: assert property (@(posedge clk) disable iff (rst)
    symbols.valid && symbols.vector_end |-> symbols.run_last)
    else $error("vector end on a combined word");

  a_last_odd: assert property (@(posedge clk) disable iff (rst)
    s0_valid && s0.last |-> s0.odd)
    else $error("vector end marked on an even subcarrier");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_ready |-> symbols.valid && s2.odd)
    else $error("sum stage stalled without pending output");
`endif

endmodule

// ===== dv/acomb_symbol_checker.sv =====
`timescale 1ns / 1ps
module acomb_symbol_checker #(
  parameter int MAX_LEN = acomb_pkg::DEF_MAX_VECTOR_LENGTH
) (
  input  logic  clk,
  input  logic  rst,
  acomb_cfg_if  cfg,
  acomb_in_if   samples,
  acomb_out_if  symbols,
  output int    err_count,
  output int    words_pending
);
  import acomb_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic                    run_last;
    logic                    vector_end;
  } symbol_word_t;

  symbol_word_t     expected_symbols[$];
  logic [CFG_W-1:0] len_reg;
  int unsigned      subcarrier_pos;
  longint           acc_re;
  longint           acc_im;
  int               mismatches = 0;

  function automatic int unsigned pair_span(input logic [CFG_W-1:0] raw);
    int unsigned n;
    n = {raw[CFG_W-1:1], 1'b0};
    if (n < LEN_MIN) n = LEN_MIN;
    if (n > MAX_LEN) n = (MAX_LEN / 2) * 2;
    return n;
  endfunction

  // q5.30 sum to q5.15, half-lsb bias then floor, saturated
  function automatic logic signed [OUT_W-1:0] to_symbol(input longint s);
    longint q;
    longint top;
    top = (longint'(1) <<< (OUT_W - 1)) - 1;
    q = (s + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    if (q > top) q = top;
    if (q < -top - 1) q = -top - 1;
    return q[OUT_W-1:0];
  endfunction

  task automatic absorb_subcarrier();
    longint r0r, r0i, r1r, r1i;
    longint h0r, h0i, h1r, h1i, h2r, h2i, h3r, h3i;
    longint sre, sim;
    logic closes;
    symbol_word_t w;
    r0r = samples.rx0_re;
    r0i = samples.rx0_im;
    r1r = samples.rx1_re;
    r1i = samples.rx1_im;
    h0r = samples.chan0_re;
    h0i = samples.chan0_im;
    h1r = samples.chan1_re;
    h1i = samples.chan1_im;
    h2r = samples.chan2_re;
    h2i = samples.chan2_im;
    h3r = samples.chan3_re;
    h3i = samples.chan3_im;
    if (subcarrier_pos[0] == 1'b0) begin
      // conj(h0)*r0 + conj(h2)*r1
      acc_re = h0r * r0r + h0i * r0i + h2r * r1r + h2i * r1i;
      acc_im = h0r * r0i - h0i * r0r + h2r * r1i - h2i * r1r;
      subcarrier_pos = subcarrier_pos + 1;
    end else begin
      // plus h1*conj(r0) + h3*conj(r1)
      sre = acc_re + h1r * r0r + h1i * r0i + h3r * r1r + h3i * r1i;
      sim = acc_im + h1i * r0r - h1r * r0i + h3i * r1r - h3r * r1i;
      closes = (subcarrier_pos + 1) >= pair_span(len_reg);
      subcarrier_pos = closes ? 0 : subcarrier_pos + 1;
      w.re         = to_symbol(sre);
      w.im         = to_symbol(sim);
      w.run_last   = 1'b0;
      w.vector_end = 1'b0;
      expected_symbols.push_back(w);
      w.re         = '0;
      w.im         = '0;
      w.run_last   = 1'b1;
      w.vector_end = closes;
      expected_symbols.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    symbol_word_t got;
    symbol_word_t want;
    if (rst) begin
      len_reg        = CFG_W'(LEN_RESET);
      subcarrier_pos = 0;
      acc_re         = 0;
      acc_im         = 0;
      expected_symbols.delete();
    end else begin
      if (cfg.valid && cfg.ready) len_reg = cfg.vector_length;
      if (symbols.valid && symbols.ready) begin
        got.re         = symbols.out_re;
        got.im         = symbols.out_im;
        got.run_last   = symbols.run_last;
        got.vector_end = symbols.vector_end;
        if (expected_symbols.size() == 0) begin
          mismatches++;
          $display("%0t unexpected word: re=%0d im=%0d run_last=%b vector_end=%b",
                   $time, got.re, got.im, got.run_last, got.vector_end);
        end else begin
          want = expected_symbols.pop_front();
          if (got.re !== want.re || got.im !== want.im ||
              got.run_last !== want.run_last || got.vector_end !== want.vector_end) begin
            mismatches++;
            $display("%0t mismatch: expected re=%0d im=%0d run_last=%b vector_end=%b",
                     $time, want.re, want.im, want.run_last, want.vector_end);
            $display("%0t           actual   re=%0d im=%0d run_last=%b vector_end=%b",
                     $time, got.re, got.im, got.run_last, got.vector_end);
          end
        end
      end
      if (samples.valid && samples.ready) absorb_subcarrier();
    end
    err_count     <= mismatches;
    words_pending <= expected_symbols.size();
  end

endmodule

// ===== dv/tb_alamouti_two_rx_combiner_core.sv =====
`timescale 1ns / 1ps
module tb_alamouti_two_rx_combiner_core;
  import acomb_pkg::*;

  logic clk = 1'b0;
  logic rst;
  int   err_count;
  int   words_pending;
  int   send_idle_pct;
  int   recv_idle_pct;

  acomb_cfg_if cfg_if ();
  acomb_in_if  samples_if ();
  acomb_out_if symbols_if ();

  alamouti_two_rx_combiner_core uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .samples (samples_if),
    .symbols (symbols_if)
  );

  acomb_symbol_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_if),
    .samples       (samples_if),
    .symbols       (symbols_if),
    .err_count     (err_count),
    .words_pending (words_pending)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb_alamouti_two_rx_combiner_core: done, errors");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] random_field();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return SAMPLE_W'($urandom_range(8) - 4);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic sample_t random_subcarrier();
    sample_t s;
    s.rx0_re   = random_field();
    s.rx0_im   = random_field();
    s.rx1_re   = random_field();
    s.rx1_im   = random_field();
    s.chan0_re = random_field();
    s.chan0_im = random_field();
    s.chan1_re = random_field();
    s.chan1_im = random_field();
    s.chan2_re = random_field();
    s.chan2_im = random_field();
    s.chan3_re = random_field();
    s.chan3_im = random_field();
    return s;
  endfunction

  function automatic logic [CFG_W-1:0] pick_length();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return CFG_W'($urandom_range(24, 2));
      6: return CFG_W'($urandom_range(1));
      7: return CFG_W'(LEN_RESET);
      8: return CFG_W'($urandom_range(4095));
      default: return CFG_W'($urandom_range(4095, 2048));
    endcase
  endfunction

  task automatic put_subcarrier(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(posedge clk);
    end
    samples_if.valid    <= 1'b1;
    samples_if.rx0_re   <= s.rx0_re;
    samples_if.rx0_im   <= s.rx0_im;
    samples_if.rx1_re   <= s.rx1_re;
    samples_if.rx1_im   <= s.rx1_im;
    samples_if.chan0_re <= s.chan0_re;
    samples_if.chan0_im <= s.chan0_im;
    samples_if.chan1_re <= s.chan1_re;
    samples_if.chan1_im <= s.chan1_im;
    samples_if.chan2_re <= s.chan2_re;
    samples_if.chan2_im <= s.chan2_im;
    samples_if.chan3_re <= s.chan3_re;
    samples_if.chan3_im <= s.chan3_im;
    do @(posedge clk); while (!samples_if.ready);
  endtask

  // even subcarriers give no word, so allow for one still in the pipe
  task automatic wait_drained();
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] len);
    wait_drained();
    cfg_if.valid         <= 1'b1;
    cfg_if.vector_length <= len;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    sample_t sc;
    int      sent;
    int      n;
    rst                   = 1'b1;
    send_idle_pct         = 0;
    recv_idle_pct         = 0;
    cfg_if.valid          = 1'b0;
    cfg_if.vector_length  = '0;
    samples_if.valid      = 1'b0;
    samples_if.rx0_re     = '0;
    samples_if.rx0_im     = '0;
    samples_if.rx1_re     = '0;
    samples_if.rx1_im     = '0;
    samples_if.chan0_re   = '0;
    samples_if.chan0_im   = '0;
    samples_if.chan1_re   = '0;
    samples_if.chan1_im   = '0;
    samples_if.chan2_re   = '0;
    samples_if.chan2_im   = '0;
    samples_if.chan3_re   = '0;
    samples_if.chan3_im   = '0;
    symbols_if.ready      = 1'b0;
    fork
      forever begin
        @(posedge clk);
        symbols_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    join_none
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // extremes at the reset length
    put_subcarrier({12{16'h8000}});
    put_subcarrier({12{16'h8000}});
    put_subcarrier({12{16'h7FFF}});
    put_subcarrier({12{16'h7FFF}});
    sc = {12{16'h7FFF}};
    sc.rx0_re = 16'h8000;
    sc.rx0_im = 16'h8000;
    sc.rx1_re = 16'h8000;
    sc.rx1_im = 16'h8000;
    put_subcarrier(sc);
    put_subcarrier(sc);
    // rounding ties, positive and negative
    sc = '0;
    sc.rx0_re   = 16'sd16384;
    sc.chan0_re = 16'sd1;
    put_subcarrier(sc);
    put_subcarrier('0);
    sc.rx0_re = -16'sd16384;
    put_subcarrier(sc);
    put_subcarrier('0);
    put_subcarrier('0);
    put_subcarrier('0);
    // length shortened mid-vector, odd subcarrier on the held partial sums
    repeat (3) put_subcarrier(random_subcarrier());
    write_length(CFG_W'(4));
    put_subcarrier(random_subcarrier());
    // tiny and oversized lengths
    write_length(CFG_W'(0));
    repeat (2) put_subcarrier(random_subcarrier());
    write_length(CFG_W'(1));
    repeat (2) put_subcarrier(random_subcarrier());
    write_length(CFG_W'(3));
    repeat (2) put_subcarrier(random_subcarrier());
    write_length(CFG_W'(4095));
    repeat (2) put_subcarrier(random_subcarrier());

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 88 : 0;
      recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 32 : 0;
      sent = 0;
      while (sent < 360) begin
        write_length(pick_length());
        n = $urandom_range(64, 8);
        repeat (n) put_subcarrier(random_subcarrier());
        sent += n;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_alamouti_two_rx_combiner_core: done, clean");
    end else begin
      $display("tb_alamouti_two_rx_combiner_core: done, errors");
    end
    $finish;
  end

endmodule
